@@ design/rffc_pkg.sv @@
// Package for the receive FIFO with RTS flow control.
// Holds command and status codes, register indexes, reset values and item types.
// No dependencies.
package rffc_pkg;

    // Widths fixed by the item and register formats
    localparam int MARK_W  = 11;
    localparam int FILL_W  = 11;
    localparam int DATA_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PORT_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK     = 2'd2;

    // Register reset values
    localparam logic [MARK_W-1:0] HIGH_MARK_RST = 11'd900;
    localparam logic [MARK_W-1:0] LOW_MARK_RST  = 11'd100;

    typedef enum logic [1:0] {
        CMD_RECEIVE  = 2'd0,
        CMD_READ     = 2'd1,
        CMD_PUT_BACK = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_OVERRUN_OK  = 2'd2,
        ST_NOT_ENABLED = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] data;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        t_status           status;
        logic              rts_enabled;
        logic [FILL_W-1:0] fill_level;
    } t_out_item;

endpackage

@@ design/rffc_ram.sv @@
// Byte store of the receive FIFO: one write port, one read port, registered read data.
// Depends on rffc_pkg for the byte width.
module rffc_ram
    import rffc_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/rx_fifo_rts_flow_control_unit.sv @@
// Receive FIFO with RTS flow control: top level.
// Pointers, count and flags sit in registers, the bytes in an rffc_ram instance.
// Depends on rffc_pkg and rffc_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one command per
//   item: receive, read, put back or clear. Output channel (o_out_valid /
//   i_out_ready / o_out_item) returns exactly one result per item: popped byte,
//   status, RTS state and fill level after the command.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_wdata) writes one of port_enabled,
//   high_mark and low_mark per write, selected by i_cfg_idx; unused indexes are ignored.
// Timing:
//   A result appears in the cycle after its item is accepted, when the byte read
//   from the store's registered port is ready. One item per cycle is sustained
//   while i_out_ready stays high: the pointer and count update completes in the
//   accept cycle, so the next command sees it.
// Stall:
//   While a result waits on i_out_ready, o_in_ready is low and the result,
//   including the read byte, is held unchanged.
// Reset:
//   Clears pointers, count, overrun and RTS hold and loads the register reset
//   values. The byte store is not cleared; the pointers never expose an
//   unwritten entry, so no clearing pass is needed.
module rx_fifo_rts_flow_control_unit
    import rffc_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MARK_W-1:0]    i_cfg_wdata
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > MARK_W) ? CW : MARK_W;
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // Configuration registers
    logic              r_port_en;
    logic [MARK_W-1:0] r_high_mark;
    logic [MARK_W-1:0] r_low_mark;

    // Buffer state
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_overrun, n_overrun;
    logic          r_rts_hold, n_rts_hold;

    // Result register
    logic              r_out_valid;
    t_status           r_out_status, n_status;
    logic              r_out_rts;
    logic [FILL_W-1:0] r_out_fill;
    logic              r_out_pop;

    logic              accept;
    logic              do_store;
    logic              do_pop;
    logic [DATA_W-1:0] ram_rdata;
    logic [CMPW-1:0]   n_count_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign do_store = (i_in_item.cmd == CMD_PUT_BACK) ||
                      ((i_in_item.cmd == CMD_RECEIVE) && r_port_en);
    assign do_pop   = (i_in_item.cmd == CMD_READ) && r_port_en && (r_count != '0);

    // Next state of pointers, count and flags for the offered item
    always_comb begin
        n_wr_idx   = r_wr_idx;
        n_rd_idx   = r_rd_idx;
        n_count    = r_count;
        n_overrun  = r_overrun;
        n_rts_hold = r_rts_hold;
        n_status   = ST_OK;
        case (i_in_item.cmd)
            CMD_RECEIVE, CMD_PUT_BACK: begin
                if (do_store) begin
                    n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + AW'(1);
                    if (r_count == FULL_CNT) begin
                        n_overrun = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    if (CMPW'(n_count) > CMPW'(r_high_mark)) begin
                        n_rts_hold = 1'b1;
                    end
                end else begin
                    n_status = ST_NOT_ENABLED;
                end
            end
            CMD_READ: begin
                if (!r_port_en) begin
                    n_status = ST_NOT_ENABLED;
                end else if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = r_overrun ? ST_OVERRUN_OK : ST_OK;
                    n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + AW'(1);
                    n_count  = r_count - CW'(1);
                    if (r_rts_hold && (CMPW'(n_count) < CMPW'(r_low_mark))) begin
                        n_rts_hold = 1'b0;
                    end
                end
            end
            CMD_CLEAR: begin
                n_wr_idx   = '0;
                n_rd_idx   = '0;
                n_count    = '0;
                n_overrun  = 1'b0;
                n_rts_hold = 1'b0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign n_count_ext = CMPW'(n_count);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_en   <= 1'b0;
            r_high_mark <= HIGH_MARK_RST;
            r_low_mark  <= LOW_MARK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PORT_ENABLED: r_port_en   <= i_cfg_wdata[0];
                REG_HIGH_MARK:    r_high_mark <= i_cfg_wdata;
                REG_LOW_MARK:     r_low_mark  <= i_cfg_wdata;
                default:          r_port_en   <= r_port_en;
            endcase
        end
    end

    // Buffer state update on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_count    <= '0;
            r_overrun  <= 1'b0;
            r_rts_hold <= 1'b0;
        end else if (accept) begin
            r_wr_idx   <= n_wr_idx;
            r_rd_idx   <= n_rd_idx;
            r_count    <= n_count;
            r_overrun  <= n_overrun;
            r_rts_hold <= n_rts_hold;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_status <= n_status;
            r_out_rts    <= !n_rts_hold;
            r_out_fill   <= n_count_ext[FILL_W-1:0];
            r_out_pop    <= do_pop;
        end
    end

    // Byte store
    rffc_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && do_store),
        .i_waddr (r_wr_idx),
        .i_wdata (i_in_item.data),
        .i_re    (accept && do_pop),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid            = r_out_valid;
    assign o_out_item.read_data   = r_out_pop ? ram_rdata : '0;
    assign o_out_item.status      = r_out_status;
    assign o_out_item.rts_enabled = r_out_rts;
    assign o_out_item.fill_level  = r_out_fill;

`ifndef SYNTHESIS
    // Count never exceeds the buffer depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= CMPW'(DEPTH))
        else $error("byte count above depth");

    // Overrun stays set until a clear is accepted
    a_overrun_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overrun && !(accept && (i_in_item.cmd == CMD_CLEAR)) |=> r_overrun)
        else $error("overrun flag dropped without clear");

    // A read never sets the RTS hold
    a_read_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in_item.cmd == CMD_READ) && !r_rts_hold |=> !r_rts_hold)
        else $error("read set the RTS hold");

    // Results with empty or not-enabled status carry zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_EMPTY ||
                        o_out_item.status == ST_NOT_ENABLED)
        |-> o_out_item.read_data == '0)
        else $error("nonzero data on a failed read");
`endif

endmodule

@@ dv/rx_fifo_rts_flow_control_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the receive FIFO with RTS flow control.
// Drives commands with random idling on both channels, predicts each result
// and checks it field by field. Depends on rffc_pkg and rx_fifo_rts_flow_control_unit.
module rx_fifo_rts_flow_control_unit_tb;
    import rffc_pkg::*;

    localparam int FIFO_DEPTH = 1024;
    localparam int MAX_GAP    = 6;
    localparam int SHOW_LIMIT = 10;

    // DUT connections
    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = REG_PORT_ENABLED;
    logic [MARK_W-1:0]    cfg_wdata = '0;

    // Shadow of the buffer state and registers
    logic [DATA_W-1:0] shadow_bytes [FIFO_DEPTH] = '{default: 8'h00};
    logic [9:0]        shadow_wr      = '0;
    logic [9:0]        shadow_rd      = '0;
    logic [FILL_W-1:0] shadow_count   = '0;
    logic              shadow_overrun = 1'b0;
    logic              shadow_hold    = 1'b0;
    logic              port_open      = 1'b0;
    logic [MARK_W-1:0] high_mark      = HIGH_MARK_RST;
    logic [MARK_W-1:0] low_mark       = LOW_MARK_RST;

    t_out_item pending_results [$];
    int        error_count   = 0;
    int        results_seen  = 0;
    int        sent_items    = 0;
    logic      tx_no_idle    = 1'b0;
    logic      rx_no_stall   = 1'b0;

    rx_fifo_rts_flow_control_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Store one byte at the write end; the count saturates at full
    function automatic void push_shadow_byte(logic [DATA_W-1:0] b);
        shadow_bytes[shadow_wr] = b;
        shadow_wr = shadow_wr + 1'b1;
        if (shadow_count == FIFO_DEPTH)
            shadow_overrun = 1'b1;
        else
            shadow_count = shadow_count + 1'b1;
        if (shadow_count > high_mark)
            shadow_hold = 1'b1;
    endfunction

    // Apply one command to the shadow state and return the result it should give
    function automatic t_out_item predict_fifo_step(t_in_item item);
        t_out_item res;
        res = '0;
        res.status = ST_OK;
        case (item.cmd)
            CMD_RECEIVE: begin
                if (port_open)
                    push_shadow_byte(item.data);
                else
                    res.status = ST_NOT_ENABLED;
            end
            CMD_READ: begin
                if (!port_open) begin
                    res.status = ST_NOT_ENABLED;
                end else if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.status = shadow_overrun ? ST_OVERRUN_OK : ST_OK;
                    res.read_data = shadow_bytes[shadow_rd];
                    shadow_rd = shadow_rd + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                    if (shadow_hold && shadow_count < low_mark)
                        shadow_hold = 1'b0;
                end
            end
            CMD_PUT_BACK: begin
                push_shadow_byte(item.data);
            end
            default: begin
                shadow_wr = '0;
                shadow_rd = '0;
                shadow_count = '0;
                shadow_overrun = 1'b0;
                shadow_hold = 1'b0;
            end
        endcase
        res.rts_enabled = !shadow_hold;
        res.fill_level = shadow_count;
        return res;
    endfunction

    // Predict on accepted items, check accepted results against the oldest prediction
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (in_valid && in_ready)
                pending_results.push_back(predict_fifo_step(in_item));
            if (out_valid && out_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= SHOW_LIMIT)
                        $display("%0t: result %0d arrived with nothing pending",
                                 $realtime, results_seen);
                end else begin
                    want = pending_results.pop_front();
                    if (out_item.read_data !== want.read_data ||
                        out_item.status !== want.status ||
                        out_item.rts_enabled !== want.rts_enabled ||
                        out_item.fill_level !== want.fill_level) begin
                        error_count++;
                        if (error_count <= SHOW_LIMIT)
                            $display({"%0t: result %0d mismatch: exp data=%02h st=%0d ",
                                      "rts=%0b fill=%0d, got data=%02h st=%0d rts=%0b fill=%0d"},
                                     $realtime, results_seen, want.read_data, want.status,
                                     want.rts_enabled, want.fill_level, out_item.read_data,
                                     out_item.status, out_item.rts_enabled,
                                     out_item.fill_level);
                    end
                end
            end
        end
    end

    // Result side: random stall before each item, with stall-free stretches
    initial begin : result_sink
        int stall;
        int served;
        served = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (served % 32 == 0)
                rx_no_stall = ($urandom_range(0, 3) == 0);
            stall = rx_no_stall ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            served++;
            @(negedge clk);
        end
    end

    // Send one command item; returns at the falling edge after it is taken
    task automatic send_cmd(t_cmd op, logic [DATA_W-1:0] byte_val);
        int gap;
        if (sent_items % 32 == 0)
            tx_no_idle = ($urandom_range(0, 3) == 0);
        sent_items++;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item <= '{cmd: op, data: byte_val};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Hold off the sender until every pending result has come back
    task automatic wait_fifo_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Write all three registers while the block is idle
    task automatic program_regs(logic en, logic [MARK_W-1:0] high, logic [MARK_W-1:0] low);
        wait_fifo_idle();
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_PORT_ENABLED;
        cfg_wdata <= {{(MARK_W-1){1'b0}}, en};
        port_open = en;
        @(negedge clk);
        cfg_idx   <= REG_HIGH_MARK;
        cfg_wdata <= high;
        high_mark = high;
        @(negedge clk);
        cfg_idx   <= REG_LOW_MARK;
        cfg_wdata <= low;
        low_mark = low;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Weighted random commands with random bytes
    task automatic run_random_cmds(int count, int w_recv, int w_read, int w_put, int w_clear);
        int   pick;
        t_cmd op;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, w_recv + w_read + w_put + w_clear - 1);
            if (pick < w_recv)
                op = CMD_RECEIVE;
            else if (pick < w_recv + w_read)
                op = CMD_READ;
            else if (pick < w_recv + w_read + w_put)
                op = CMD_PUT_BACK;
            else
                op = CMD_CLEAR;
            send_cmd(op, 8'($urandom_range(0, 255)));
            // occasional full drain
            if ($urandom_range(0, 99) == 0)
                wait_fifo_idle();
        end
    endtask

    // Reset registers: port closed, so receive and read are refused
    task automatic test_closed_port_at_reset();
        send_cmd(CMD_RECEIVE, 8'h00);
        send_cmd(CMD_READ, 8'h00);
        send_cmd(CMD_PUT_BACK, 8'hFF);
        send_cmd(CMD_READ, 8'hFF);
        send_cmd(CMD_CLEAR, 8'h00);
    endtask

    // Tight marks: hold set above high, released below low, clear drops hold
    task automatic test_rts_hysteresis();
        program_regs(1'b1, 11'd2, 11'd1);
        send_cmd(CMD_READ, 8'h00);
        send_cmd(CMD_RECEIVE, 8'hA5);
        send_cmd(CMD_RECEIVE, 8'h5A);
        send_cmd(CMD_PUT_BACK, 8'hFF);
        send_cmd(CMD_RECEIVE, 8'h00);
        repeat (4) send_cmd(CMD_READ, 8'h00);
        send_cmd(CMD_READ, 8'hFF);
        send_cmd(CMD_RECEIVE, 8'h80);
        send_cmd(CMD_RECEIVE, 8'h7F);
        send_cmd(CMD_PUT_BACK, 8'h01);
        send_cmd(CMD_CLEAR, 8'hFF);
        send_cmd(CMD_READ, 8'h00);
    endtask

    // Zero marks: one byte sets hold, and no read can release it
    task automatic test_zero_marks();
        program_regs(1'b1, 11'd0, 11'd0);
        send_cmd(CMD_RECEIVE, 8'h3C);
        send_cmd(CMD_READ, 8'h00);
        send_cmd(CMD_READ, 8'h00);
        send_cmd(CMD_CLEAR, 8'h00);
    endtask

    // Port closed with data buffered: put back still stores
    task automatic test_closed_port_with_data();
        program_regs(1'b0, HIGH_MARK_RST, LOW_MARK_RST);
        send_cmd(CMD_PUT_BACK, 8'h11);
        send_cmd(CMD_READ, 8'h00);
        send_cmd(CMD_RECEIVE, 8'h22);
    endtask

    // Random traffic around small marks
    task automatic test_random_small_marks();
        repeat (2) begin
            program_regs(1'b1, 11'($urandom_range(0, 16)), 11'($urandom_range(0, 16)));
            run_random_cmds(40, 30, 35, 25, 10);
        end
    endtask

    // Store-heavy traffic until the buffer wraps past full, then drain with overrun status
    task automatic test_fill_to_overrun();
        int n;
        program_regs(1'b1, 11'd1023, 11'd1024);
        n = 0;
        while (!shadow_overrun && n < 1400) begin
            run_random_cmds(1, 48, 3, 48, 0);
            n++;
        end
        run_random_cmds(30, 45, 10, 45, 0);
        wait_fifo_idle();
        run_random_cmds(20, 5, 90, 5, 0);
    endtask

    // Random traffic across extreme and random register settings
    task automatic test_random_mixed();
        program_regs(1'b1, 11'd1024, 11'd0);
        run_random_cmds(20, 35, 35, 25, 5);
        program_regs(1'b0, 11'($urandom_range(0, 1024)), 11'($urandom_range(0, 1024)));
        run_random_cmds(15, 30, 30, 30, 10);
        program_regs(1'b1, 11'd0, 11'd1024);
        run_random_cmds(15, 30, 40, 25, 5);
        program_regs(1'b1, 11'($urandom_range(0, 1024)), 11'($urandom_range(0, 1024)));
        run_random_cmds(20, 30, 35, 30, 5);
    endtask

    initial begin : stimulus
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_closed_port_at_reset();
        test_rts_hysteresis();
        test_zero_marks();
        test_closed_port_with_data();
        test_random_small_marks();
        test_fill_to_overrun();
        test_random_mixed();
        wait_fifo_idle();
        repeat (4) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin : watchdog
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
design/rffc_pkg.sv
design/rffc_ram.sv
design/rx_fifo_rts_flow_control_unit.sv
dv/rx_fifo_rts_flow_control_unit_tb.sv
